FILE: rtl/dsf_pkg.sv
package dsf_pkg;

  localparam int FRACTION_BITS = 32;
  localparam int INTEGER_BITS  = 32;
  localparam int Q_W           = INTEGER_BITS + FRACTION_BITS;
  localparam int INT_EXT_W     = INTEGER_BITS + 4;
  localparam int CODE_W        = 16;
  localparam int STATUS_W      = 3;
  localparam int VALUE_W       = 64;
  localparam int FRAC_ACC_W    = 32;
  localparam int IDX_W         = 4;
  localparam int DIGIT_W       = 4;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SAT        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADCHAR    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPOINT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TRAILPOINT = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NODIGITS   = 3'd6;

  localparam logic [CODE_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CODE_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CODE_W-1:0] CH_POINT = 16'h002E;
  localparam logic [CODE_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CODE_W-1:0] CH_NINE  = 16'h0039;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  // -1.0 in the chosen fixed-point format
  localparam logic [VALUE_W-1:0] MINUS_ONE =
    ~((VALUE_W'(1) << FRACTION_BITS) - VALUE_W'(1));

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } dsf_result_t;

  // floor(2^32 / 10^(idx+1))
  function automatic logic [FRAC_ACC_W-1:0] tenth_power(input logic [IDX_W-1:0] idx);
    logic [FRAC_ACC_W-1:0] r;
    case (idx)
      4'd0:    r = 32'd429496729;
      4'd1:    r = 32'd42949672;
      4'd2:    r = 32'd4294967;
      4'd3:    r = 32'd429496;
      4'd4:    r = 32'd42949;
      4'd5:    r = 32'd4294;
      4'd6:    r = 32'd429;
      4'd7:    r = 32'd42;
      4'd8:    r = 32'd4;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/decimal_string_to_fixed.sv
// decimal string to signed fixed-point converter
// input channel: one UTF-16 code unit per transaction on in_code_unit; a zero
//   code unit ends the string and produces exactly one result transaction,
//   other code units produce none
// result channel: out_status and out_value (signed Q32.32, -1.0 on a bad string)
// config: cfg_wr_en writes cfg_wr_data into allow_fraction; write only while idle
// throughput: one code unit per cycle; the parse state updates once per
//   code unit in a single registered pass (times-ten add or fraction table add)
// latency: a terminator accepted at edge n shows its result after edge n+1
// stall: the output register keeps its result while out_stall is high; code
//   units that are not terminators still drain, and in_stall rises only when a
//   terminator waits behind an unread result
// reset (rst_n low, synchronous): allow_fraction returns to 1, the parse
//   state clears and no result is pending
module decimal_string_to_fixed
  import dsf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CODE_W-1:0]         in_code_unit,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_value,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data
);

  logic                allow_fraction_r;
  logic                s1_valid_r;
  logic [CODE_W-1:0]   s1_code_r;
  logic                out_valid_r;
  dsf_result_t         out_r;
  dsf_result_t         result;
  logic                s1_term;
  logic                s1_block;
  logic                s1_step;
  logic                in_take;

  assign s1_term  = (s1_code_r == CH_NUL);
  // terminator can only move on when the output register frees up
  assign s1_block = s1_valid_r && s1_term && out_valid_r && out_stall;
  assign s1_step  = s1_valid_r && !s1_block;
  assign in_stall = s1_block;
  assign in_take  = in_valid && !in_stall;

  dsf_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (s1_step),
    .code           (s1_code_r),
    .allow_fraction (allow_fraction_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_fraction_r <= 1'b1;
    end else if (cfg_wr_en) begin
      allow_fraction_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_block) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r <= in_code_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_step && s1_term) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_term) begin
      out_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_r.status;
  assign out_value  = $signed(out_r.value);

endmodule

FILE: rtl/dsf_parse.sv
module dsf_parse
  import dsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [CODE_W-1:0] code,
  input  logic              allow_fraction,
  output dsf_result_t       result
);

  logic                    at_start_r, at_start_nxt;
  logic                    is_negative_r, is_negative_nxt;
  logic                    after_point_r, after_point_nxt;
  logic                    seen_digit_r, seen_digit_nxt;
  logic                    point_was_last_r, point_was_last_nxt;
  logic [STATUS_W-1:0]     fault_code_r, fault_code_nxt;
  logic                    saturated_r, saturated_nxt;
  logic [INTEGER_BITS-1:0] int_acc_r, int_acc_nxt;
  logic [FRAC_ACC_W-1:0]   frac_acc_r, frac_acc_nxt;
  logic [IDX_W-1:0]        frac_idx_r, frac_idx_nxt;

  logic                    dec_char;
  logic [DIGIT_W-1:0]      digit;
  logic [INT_EXT_W-1:0]    int_ext;
  logic [INT_EXT_W-1:0]    int_next;
  logic [INT_EXT_W-1:0]    int_limit;
  logic [FRAC_ACC_W-1:0]   frac_term;

  logic [Q_W-1:0]          mag;
  logic [Q_W-1:0]          top;
  logic                    clamp;
  logic [Q_W-1:0]          mag_cl;
  logic signed [Q_W-1:0]   q_val;

  assign dec_char  = (code >= CH_ZERO) && (code <= CH_NINE);
  assign digit     = DIGIT_W'(code - CH_ZERO);
  assign int_ext   = INT_EXT_W'(int_acc_r);
  // times ten as two shifts
  assign int_next  = (int_ext << 3) + (int_ext << 1) + INT_EXT_W'(digit);
  assign int_limit = INT_EXT_W'(1) << (INTEGER_BITS - 1);
  assign frac_term = FRAC_ACC_W'(digit * tenth_power(frac_idx_r));

  always_comb begin
    at_start_nxt       = at_start_r;
    is_negative_nxt    = is_negative_r;
    after_point_nxt    = after_point_r;
    seen_digit_nxt     = seen_digit_r;
    point_was_last_nxt = point_was_last_r;
    fault_code_nxt     = fault_code_r;
    saturated_nxt      = saturated_r;
    int_acc_nxt        = int_acc_r;
    frac_acc_nxt       = frac_acc_r;
    frac_idx_nxt       = frac_idx_r;
    if (code == CH_NUL) begin
      at_start_nxt       = 1'b1;
      is_negative_nxt    = 1'b0;
      after_point_nxt    = 1'b0;
      seen_digit_nxt     = 1'b0;
      point_was_last_nxt = 1'b0;
      fault_code_nxt     = ST_OK;
      saturated_nxt      = 1'b0;
      int_acc_nxt        = '0;
      frac_acc_nxt       = '0;
      frac_idx_nxt       = '0;
    end else begin
      at_start_nxt = 1'b0;
      if (fault_code_r == ST_OK) begin
        if (at_start_r && code == CH_MINUS) begin
          is_negative_nxt = 1'b1;
        end else if (code == CH_POINT) begin
          if (!allow_fraction || after_point_r || !seen_digit_r) begin
            fault_code_nxt = ST_BADPOINT;
          end else begin
            after_point_nxt    = 1'b1;
            point_was_last_nxt = 1'b1;
          end
        end else if (dec_char) begin
          seen_digit_nxt     = 1'b1;
          point_was_last_nxt = 1'b0;
          if (after_point_r) begin
            frac_acc_nxt = frac_acc_r + frac_term;
            if (frac_idx_r != IDX_MAX) begin
              frac_idx_nxt = frac_idx_r + IDX_W'(1);
            end
          end else if (int_next > int_limit) begin
            int_acc_nxt   = INTEGER_BITS'(int_limit);
            saturated_nxt = 1'b1;
          end else begin
            int_acc_nxt = INTEGER_BITS'(int_next);
          end
        end else begin
          fault_code_nxt = ST_BADCHAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r       <= 1'b1;
      is_negative_r    <= 1'b0;
      after_point_r    <= 1'b0;
      seen_digit_r     <= 1'b0;
      point_was_last_r <= 1'b0;
      fault_code_r     <= ST_OK;
      saturated_r      <= 1'b0;
      int_acc_r        <= '0;
      frac_acc_r       <= '0;
      frac_idx_r       <= '0;
    end else if (step_en) begin
      at_start_r       <= at_start_nxt;
      is_negative_r    <= is_negative_nxt;
      after_point_r    <= after_point_nxt;
      seen_digit_r     <= seen_digit_nxt;
      point_was_last_r <= point_was_last_nxt;
      fault_code_r     <= fault_code_nxt;
      saturated_r      <= saturated_nxt;
      int_acc_r        <= int_acc_nxt;
      frac_acc_r       <= frac_acc_nxt;
      frac_idx_r       <= frac_idx_nxt;
    end
  end

  // final value from the accumulated state, used when the terminator arrives
  assign mag    = {int_acc_r, frac_acc_r[FRAC_ACC_W-1 -: FRACTION_BITS]};
  assign top    = Q_W'(1) << (Q_W - 1);
  assign clamp  = is_negative_r ? (mag[Q_W-1] && (|mag[Q_W-2:0])) : mag[Q_W-1];
  assign mag_cl = clamp ? (is_negative_r ? top : top - Q_W'(1)) : mag;
  assign q_val  = is_negative_r ? -$signed(mag_cl) : $signed(mag_cl);

  always_comb begin
    result.value = MINUS_ONE;
    if (at_start_r) begin
      result.status = ST_EMPTY;
    end else if (fault_code_r != ST_OK) begin
      result.status = fault_code_r;
    end else if (!seen_digit_r) begin
      result.status = ST_NODIGITS;
    end else if (point_was_last_r) begin
      result.status = ST_TRAILPOINT;
    end else begin
      result.status = (saturated_r || clamp) ? ST_SAT : ST_OK;
      result.value  = VALUE_W'(q_val);
    end
  end

endmodule
